/* hdl/voxel_exposure_scan_top_macros.svh */
// Assertion macros for the files that check their own behaviour.
`ifndef VOXEL_EXPOSURE_SCAN_TOP_MACROS_SVH
`define VOXEL_EXPOSURE_SCAN_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VES_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ves_pkg.sv */
package ves_pkg;

    localparam int EDGE_DEF    = 16;
    localparam int ID_BITS_DEF = 16;
    localparam int COORD_W     = 4;
    localparam int ID_W        = 16;
    localparam int CMD_W       = 2;
    localparam int STEP_W      = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

    // Read steps of one voxel: which neighbours the two RAM ports fetch.
    localparam logic [STEP_W-1:0] STEP_C_XP  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_XM_YP = 2'd1;
    localparam logic [STEP_W-1:0] STEP_YM_ZP = 2'd2;
    localparam logic [STEP_W-1:0] STEP_ZM    = 2'd3;

    typedef struct packed {
        logic              load;
        logic              clr_en;
        logic              rd_en;
        logic [STEP_W-1:0] rd_step;
        logic              cap_en;
        logic [STEP_W-1:0] cap_step;
        logic              emit;
        logic              z_inc;
    } ves_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic last_voxel;
    } ves_stat_t;

endpackage

/* hdl/ves_ram.sv */
module ves_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hdl/ves_ctrl.sv */
module ves_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [ves_pkg::CMD_W-1:0]     s_cmd,
    output logic                          s_ready,
    input  ves_pkg::ves_stat_t            stat,
    output ves_pkg::ves_cmd_t             cmd
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD0  = 3'd2;
    localparam logic [2:0] ST_RD1  = 3'd3;
    localparam logic [2:0] ST_RD2  = 3'd4;
    localparam logic [2:0] ST_RD3  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_cmd == ves_pkg::CMD_READ || s_cmd == ves_pkg::CMD_SCAN) begin
                        state_next = ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_step = ves_pkg::STEP_C_XP;
                state_next  = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_step  = ves_pkg::STEP_XM_YP;
                cmd.cap_en   = 1'b1;
                cmd.cap_step = ves_pkg::STEP_C_XP;
                state_next   = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_step  = ves_pkg::STEP_YM_ZP;
                cmd.cap_en   = 1'b1;
                cmd.cap_step = ves_pkg::STEP_XM_YP;
                state_next   = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_step  = ves_pkg::STEP_ZM;
                cmd.cap_en   = 1'b1;
                cmd.cap_step = ves_pkg::STEP_YM_ZP;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                cmd.cap_en   = 1'b1;
                cmd.cap_step = ves_pkg::STEP_ZM;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.last_voxel) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.z_inc  = 1'b1;
                        state_next = ST_RD0;
                    end
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

endmodule

/* hdl/ves_dp.sv */
module ves_dp #(
    parameter int EDGE    = ves_pkg::EDGE_DEF,
    parameter int ID_BITS = ves_pkg::ID_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ves_pkg::CMD_W-1:0]   s_cmd,
    input  logic [ves_pkg::COORD_W-1:0] s_pos_x,
    input  logic [ves_pkg::COORD_W-1:0] s_pos_y,
    input  logic [ves_pkg::COORD_W-1:0] s_pos_z,
    input  logic [ves_pkg::ID_W-1:0]    s_write_id,
    input  ves_pkg::ves_cmd_t           cmd,
    output ves_pkg::ves_stat_t          stat,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ves_pkg::COORD_W-1:0] m_out_x,
    output logic [ves_pkg::COORD_W-1:0] m_out_y,
    output logic [ves_pkg::COORD_W-1:0] m_out_z,
    output logic [ves_pkg::ID_W-1:0]    m_block_id,
    output logic                        m_exposed,
    output logic                        m_last
);

    localparam int AW       = (EDGE > 1) ? $clog2(EDGE) : 1;
    localparam int ADDR_W   = 3 * AW;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int SCAN_LEN = (EDGE < 16) ? EDGE : 16;
    localparam int CMP_W    = 8;
    localparam int CW       = ves_pkg::COORD_W;

    localparam logic [CMP_W-1:0]  EDGE_C = CMP_W'(EDGE);
    localparam logic [CW-1:0]     LAST_Z = CW'(SCAN_LEN - 1);
    localparam logic [CW-1:0]     MAX_C  = '1;
    localparam logic [CW-1:0]     ONE_C  = CW'(1);
    localparam logic [ADDR_W-1:0] ONE_A  = ADDR_W'(1);

    function automatic logic in_grid(input logic [CW-1:0] c);
        in_grid = CMP_W'(c) < EDGE_C;
    endfunction

    // Upper neighbour lies outside, or at a coordinate no write can reach.
    function automatic logic hi_out(input logic [CW-1:0] c);
        hi_out = (c == MAX_C) || ((CMP_W'(c) + CMP_W'(1)) >= EDGE_C);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y,
                                                  input logic [CW-1:0] z);
        addr_of = {AW'(x), AW'(y), AW'(z)};
    endfunction

    logic [CW-1:0]              x_reg, y_reg, z_reg;
    logic [ves_pkg::CMD_W-1:0]  op_reg;
    logic [ID_BITS-1:0]         id_reg;
    logic                       zero_reg;
    logic [ADDR_W-1:0]          clr_cnt_reg;

    logic                       m_valid_reg;
    logic [CW-1:0]              out_x_reg, out_y_reg, out_z_reg;
    logic [ves_pkg::ID_W-1:0]   block_id_reg;
    logic                       exposed_reg;
    logic                       last_reg;

    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic [ID_BITS-1:0]         wdata;
    logic [ADDR_W-1:0]          raddr_a, raddr_b;
    logic [ID_BITS-1:0]         rdata_a, rdata_b;

    logic                       center_in;
    logic                       out_a, out_b, use_b;
    logic                       nb_zero_a, nb_zero_b;
    logic                       last_voxel;

    assign center_in  = in_grid(x_reg) && in_grid(y_reg) && in_grid(z_reg);
    assign last_voxel = (op_reg == ves_pkg::CMD_READ) || (z_reg == LAST_Z);

    // Write port: the clearing sweep after reset, otherwise a write item.
    always_comb begin
        if (cmd.clr_en) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end else begin
            we    = cmd.load && (s_cmd == ves_pkg::CMD_WRITE) &&
                    in_grid(s_pos_x) && in_grid(s_pos_y) && in_grid(s_pos_z);
            waddr = addr_of(s_pos_x, s_pos_y, s_pos_z);
            wdata = ID_BITS'(s_write_id);
        end
    end

    always_comb begin
        case (cmd.rd_step)
            ves_pkg::STEP_C_XP: begin
                raddr_a = addr_of(x_reg, y_reg, z_reg);
                raddr_b = addr_of(x_reg + ONE_C, y_reg, z_reg);
            end
            ves_pkg::STEP_XM_YP: begin
                raddr_a = addr_of(x_reg - ONE_C, y_reg, z_reg);
                raddr_b = addr_of(x_reg, y_reg + ONE_C, z_reg);
            end
            ves_pkg::STEP_YM_ZP: begin
                raddr_a = addr_of(x_reg, y_reg - ONE_C, z_reg);
                raddr_b = addr_of(x_reg, y_reg, z_reg + ONE_C);
            end
            default: begin
                raddr_a = addr_of(x_reg, y_reg, z_reg - ONE_C);
                raddr_b = addr_of(x_reg, y_reg, z_reg);
            end
        endcase
    end

    ves_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (cmd.rd_en),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Which returned words are neighbours, and which neighbours are off the grid.
    always_comb begin
        out_a = 1'b0;
        out_b = 1'b0;
        use_b = 1'b1;
        case (cmd.cap_step)
            ves_pkg::STEP_C_XP: begin
                out_b = hi_out(x_reg);
            end
            ves_pkg::STEP_XM_YP: begin
                out_a = (x_reg == '0);
                out_b = hi_out(y_reg);
            end
            ves_pkg::STEP_YM_ZP: begin
                out_a = (y_reg == '0);
                out_b = hi_out(z_reg);
            end
            default: begin
                out_a = (z_reg == '0);
                use_b = 1'b0;
            end
        endcase
    end

    assign nb_zero_a = out_a || (rdata_a == '0);
    assign nb_zero_b = use_b && (out_b || (rdata_b == '0));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_cmd;
            x_reg  <= s_pos_x;
            y_reg  <= s_pos_y;
            z_reg  <= (s_cmd == ves_pkg::CMD_SCAN) ? '0 : s_pos_z;
        end else if (cmd.z_inc) begin
            z_reg  <= z_reg + ONE_C;
        end
        if (cmd.cap_en) begin
            if (cmd.cap_step == ves_pkg::STEP_C_XP) begin
                id_reg   <= center_in ? rdata_a : '0;
                zero_reg <= nb_zero_b;
            end else begin
                zero_reg <= zero_reg | nb_zero_a | nb_zero_b;
            end
        end
        if (cmd.emit) begin
            out_x_reg    <= x_reg;
            out_y_reg    <= y_reg;
            out_z_reg    <= z_reg;
            block_id_reg <= ves_pkg::ID_W'(id_reg);
            exposed_reg  <= (id_reg != '0) && zero_reg;
            last_reg     <= last_voxel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_en) begin
                clr_cnt_reg <= clr_cnt_reg + ONE_A;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clr_done   = (clr_cnt_reg == '1);
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.last_voxel = last_voxel;

    assign m_valid    = m_valid_reg;
    assign m_out_x    = out_x_reg;
    assign m_out_y    = out_y_reg;
    assign m_out_z    = out_z_reg;
    assign m_block_id = block_id_reg;
    assign m_exposed  = exposed_reg;
    assign m_last     = last_reg;

endmodule

/* hdl/voxel_exposure_scan_top.sv */
// Voxel exposure scan: a cubic grid of block ids (EDGE per side) held in one RAM with a
// write port and two registered read ports. A write item stores its id (truncated to
// ID_BITS). A read item returns one result, and a scan item returns one result per z of
// the named x,y column, z rising from zero, with last on the final one. Each result flags
// the voxel exposed when its id is nonzero and at least one of its six face neighbours is
// empty or off the grid. For every voxel, seven words (the voxel and its six neighbours)
// are fetched through the two read ports in the read steps, then one state collects the
// last word and one loads the output register, waiting while that register is still full.
// The output register lets the next item be taken while the final result still waits on
// m_ready. After reset the grid is cleared by a sweep of one entry per cycle over all
// 8^ceil(log2 EDGE) entries (4096 at EDGE = 16), during which s_ready stays low.
`include "voxel_exposure_scan_top_macros.svh"

module voxel_exposure_scan_top #(
    parameter int EDGE    = ves_pkg::EDGE_DEF,
    parameter int ID_BITS = ves_pkg::ID_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ves_pkg::CMD_W-1:0]   s_cmd,
    input  logic [ves_pkg::COORD_W-1:0] s_pos_x,
    input  logic [ves_pkg::COORD_W-1:0] s_pos_y,
    input  logic [ves_pkg::COORD_W-1:0] s_pos_z,
    input  logic [ves_pkg::ID_W-1:0]    s_write_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ves_pkg::COORD_W-1:0] m_out_x,
    output logic [ves_pkg::COORD_W-1:0] m_out_y,
    output logic [ves_pkg::COORD_W-1:0] m_out_z,
    output logic [ves_pkg::ID_W-1:0]    m_block_id,
    output logic                        m_exposed,
    output logic                        m_last
);

    // Commands run from the sequencer to the datapath; status comes back.
    ves_pkg::ves_cmd_t  ctrl_cmd;
    ves_pkg::ves_stat_t dp_stat;

    // The sequencer walks each voxel through its read steps and waits for room
    // in the output register before moving on.
    ves_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd)
    );

    // The datapath holds the grid RAM, the current item's coordinates, the
    // neighbour test and the output register.
    ves_dp #(
        .EDGE    (EDGE),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_cmd      (s_cmd),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_write_id (s_write_id),
        .cmd        (ctrl_cmd),
        .stat       (dp_stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_z    (m_out_z),
        .m_block_id (m_block_id),
        .m_exposed  (m_exposed),
        .m_last     (m_last)
    );

    // No item may enter while the clearing sweep is still writing the grid.
    `VES_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, ctrl_cmd.clr_en, !s_ready, "item accepted during clearing sweep")

    // A read or scan item occupies the block, so the next cycle cannot accept.
    `VES_ASSERT_NEXT(a_busy_after_lookup, aclk, aresetn, s_valid && s_ready && (s_cmd == ves_pkg::CMD_READ || s_cmd == ves_pkg::CMD_SCAN), !s_ready, "accepted item while a lookup was starting")

    // While a scan has results still to come, no new item is taken.
    `VES_ASSERT_NOW(a_scan_holds_input, aclk, aresetn, m_valid && m_ready && !m_last, !s_ready, "input accepted in the middle of a scan")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// One result item as the block reports it.
typedef struct packed {
    logic [ves_pkg::COORD_W-1:0] x;
    logic [ves_pkg::COORD_W-1:0] y;
    logic [ves_pkg::COORD_W-1:0] z;
    logic [ves_pkg::ID_W-1:0]    id;
    logic                        exposed;
    logic                        last;
} voxel_report_t;

// Keeps a private copy of the voxel grid, works out the reports that each
// accepted command item causes and checks the block's results against them.
class voxel_exposure_board;
    logic [ves_pkg::ID_W-1:0] grid [ves_pkg::EDGE_DEF][ves_pkg::EDGE_DEF][ves_pkg::EDGE_DEF];
    voxel_report_t            awaited [$];
    int unsigned              failures;
    int unsigned              checked;

    function new();
        foreach (grid[i, j, k]) grid[i][j][k] = '0;
        failures = 0;
        checked  = 0;
    endfunction

    // Anything off the grid reads as an empty voxel.
    function logic [ves_pkg::ID_W-1:0] fetch(int x, int y, int z);
        if (x < 0 || x >= ves_pkg::EDGE_DEF || y < 0 || y >= ves_pkg::EDGE_DEF ||
            z < 0 || z >= ves_pkg::EDGE_DEF) begin
            return '0;
        end
        return grid[x][y][z];
    endfunction

    function void add_report(int x, int y, int z, bit last);
        voxel_report_t rpt;
        rpt.x       = ves_pkg::COORD_W'(x);
        rpt.y       = ves_pkg::COORD_W'(y);
        rpt.z       = ves_pkg::COORD_W'(z);
        rpt.id      = fetch(x, y, z);
        rpt.exposed = (rpt.id != '0) &&
                      (fetch(x + 1, y, z) == '0 || fetch(x - 1, y, z) == '0 ||
                       fetch(x, y + 1, z) == '0 || fetch(x, y - 1, z) == '0 ||
                       fetch(x, y, z + 1) == '0 || fetch(x, y, z - 1) == '0);
        rpt.last    = last;
        awaited.insert(awaited.size(), rpt);
    endfunction

    function void note_item(logic [ves_pkg::CMD_W-1:0] cmd, int x, int y, int z,
                            logic [ves_pkg::ID_W-1:0] wid);
        int scan_len;
        scan_len = (ves_pkg::EDGE_DEF < 16) ? ves_pkg::EDGE_DEF : 16;
        case (cmd)
            ves_pkg::CMD_WRITE: begin
                if (x < ves_pkg::EDGE_DEF && y < ves_pkg::EDGE_DEF && z < ves_pkg::EDGE_DEF) begin
                    grid[x][y][z] = wid & ves_pkg::ID_W'((64'd1 << ves_pkg::ID_BITS_DEF) - 1);
                end
            end
            ves_pkg::CMD_READ: begin
                add_report(x, y, z, 1'b1);
            end
            ves_pkg::CMD_SCAN: begin
                for (int k = 0; k < scan_len; k++) add_report(x, y, k, k == scan_len - 1);
            end
            default: begin
            end
        endcase
    endfunction

    function void compare_field(string name, logic [ves_pkg::ID_W-1:0] want,
                                logic [ves_pkg::ID_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
        end
    endfunction

    function void check_result(voxel_report_t got);
        voxel_report_t want;
        checked++;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result, actual x %0d y %0d z %0d id %0h", $time,
                     got.x, got.y, got.z, got.id);
            failures++;
            return;
        end
        want = awaited.pop_front();
        compare_field("out_x", ves_pkg::ID_W'(want.x), ves_pkg::ID_W'(got.x));
        compare_field("out_y", ves_pkg::ID_W'(want.y), ves_pkg::ID_W'(got.y));
        compare_field("out_z", ves_pkg::ID_W'(want.z), ves_pkg::ID_W'(got.z));
        compare_field("block_id", want.id, got.id);
        compare_field("exposed", ves_pkg::ID_W'(want.exposed), ves_pkg::ID_W'(got.exposed));
        compare_field("last", ves_pkg::ID_W'(want.last), ves_pkg::ID_W'(got.last));
    endfunction

    function int unsigned pending();
        return awaited.size();
    endfunction
endclass

module testbench;

    // Command code that the block must ignore altogether.
    localparam logic [ves_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int COORD_MAX        = ves_pkg::EDGE_DEF - 1;
    localparam int RANDOM_ITEMS     = 200;
    // The receiver goes deaf for this long once, after this many results.
    localparam int LONG_HOLD_AFTER  = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    // Long enough for any straggler, such as a full scan, to finish.
    localparam int TAIL_CYCLES      = 150;
    // The clearing sweep after reset plus the long hold must fit.
    localparam int QUIET_LIMIT      = 20000;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [ves_pkg::CMD_W-1:0]   s_cmd;
    logic [ves_pkg::COORD_W-1:0] s_pos_x;
    logic [ves_pkg::COORD_W-1:0] s_pos_y;
    logic [ves_pkg::COORD_W-1:0] s_pos_z;
    logic [ves_pkg::ID_W-1:0]    s_write_id;
    logic                        m_valid;
    logic                        m_ready;
    logic [ves_pkg::COORD_W-1:0] m_out_x;
    logic [ves_pkg::COORD_W-1:0] m_out_y;
    logic [ves_pkg::COORD_W-1:0] m_out_z;
    logic [ves_pkg::ID_W-1:0]    m_block_id;
    logic                        m_exposed;
    logic                        m_last;

    voxel_exposure_board board = new();

    // Offsets of a voxel and its six face neighbours, centre first.
    int face_dx [7] = '{0, 1, -1, 0, 0, 0, 0};
    int face_dy [7] = '{0, 0, 0, 1, -1, 0, 0};
    int face_dz [7] = '{0, 0, 0, 0, 0, 1, -1};

    int unsigned item_count;
    int unsigned sender_calm;
    int unsigned receiver_calm;
    int unsigned quiet_cycles = 0;

    voxel_exposure_scan_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_write_id (s_write_id),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_z    (m_out_z),
        .m_block_id (m_block_id),
        .m_exposed  (m_exposed),
        .m_last     (m_last)
    );

    always #2 aclk = ~aclk;

    // Gap lengths for both sides: mostly none or a few cycles, now and then a long
    // one. Occasionally a calm stretch starts in which no gap is taken at all.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Ids lean towards empty and all-ones so that exposure flips often.
    function automatic logic [ves_pkg::ID_W-1:0] pick_id();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return ves_pkg::ID_W'($urandom);
    endfunction

    function automatic bit on_grid(int c);
        return c >= 0 && c <= COORD_MAX;
    endfunction

    // Offers one command item and holds it until the block takes it. Valid is only
    // raised when it is low, so back-to-back items keep it high without a glitch.
    task automatic send_item(input logic [ves_pkg::CMD_W-1:0] cmd,
                             input int x, input int y, input int z,
                             input logic [ves_pkg::ID_W-1:0] wid);
        int unsigned gap;
        if (!s_valid) s_valid <= 1'b1;
        s_cmd      <= cmd;
        s_pos_x    <= ves_pkg::COORD_W'(x);
        s_pos_y    <= ves_pkg::COORD_W'(y);
        s_pos_z    <= ves_pkg::COORD_W'(z);
        s_write_id <= wid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(cmd, x & COORD_MAX, y & COORD_MAX, z & COORD_MAX, wid);
        if (cmd != CMD_UNUSED) item_count++;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every outstanding result has been checked.
    task automatic drain_results();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (board.pending() != 0) @(posedge aclk);
    endtask

    // A voxel with all six face neighbours written, then read back; now and then
    // its whole column is scanned too. Neighbours that fall off the grid are
    // skipped, so clusters on the border stay exposed through the edge.
    task automatic build_cluster();
        int cx;
        int cy;
        int cz;
        cx = $urandom_range(0, COORD_MAX);
        cy = $urandom_range(0, COORD_MAX);
        cz = $urandom_range(0, COORD_MAX);
        for (int k = 0; k < 7; k++) begin
            if (on_grid(cx + face_dx[k]) && on_grid(cy + face_dy[k]) &&
                on_grid(cz + face_dz[k])) begin
                send_item(ves_pkg::CMD_WRITE, cx + face_dx[k], cy + face_dy[k],
                          cz + face_dz[k], pick_id());
            end
        end
        send_item(ves_pkg::CMD_READ, cx, cy, cz, ves_pkg::ID_W'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            send_item(ves_pkg::CMD_SCAN, cx, cy, $urandom_range(0, COORD_MAX),
                      ves_pkg::ID_W'($urandom));
        end
    endtask

    // Stimulus: a directed opening, a pause until the grid is quiet, then random
    // clusters mixed with loose items of every command, including the unused one.
    initial begin : command_source
        int unsigned random_start;
        bit          paused;
        s_valid      = 1'b0;
        s_cmd        = ves_pkg::CMD_WRITE;
        s_pos_x      = '0;
        s_pos_y      = '0;
        s_pos_z      = '0;
        s_write_id   = '0;
        aresetn      = 1'b0;
        item_count   = 0;
        sender_calm  = 0;
        paused       = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // The freshly cleared grid reads back empty and unexposed.
        send_item(ves_pkg::CMD_READ, 0, 0, 0, '0);
        // Corner voxels, one with the widest id: exposed through the grid boundary.
        send_item(ves_pkg::CMD_WRITE, 0, 0, 0, '1);
        send_item(ves_pkg::CMD_READ, 0, 0, 0, '0);
        send_item(ves_pkg::CMD_WRITE, COORD_MAX, COORD_MAX, COORD_MAX, 16'd1);
        send_item(ves_pkg::CMD_READ, COORD_MAX, COORD_MAX, COORD_MAX, '1);
        // A scan ignores its z, so give it a nonzero one.
        send_item(ves_pkg::CMD_SCAN, COORD_MAX, COORD_MAX, 9, '1);
        // Writing zero empties a voxel again.
        send_item(ves_pkg::CMD_WRITE, COORD_MAX, COORD_MAX, COORD_MAX, '0);
        send_item(ves_pkg::CMD_READ, COORD_MAX, COORD_MAX, COORD_MAX, '0);
        // The unused command must neither store nor report anything.
        send_item(CMD_UNUSED, 0, 0, 0, 16'h1234);
        send_item(ves_pkg::CMD_READ, 0, 0, 0, '0);
        // A fully enclosed voxel is hidden; the scan sees it between exposed ones.
        for (int k = 0; k < 7; k++) begin
            send_item(ves_pkg::CMD_WRITE, 5 + face_dx[k], 6 + face_dy[k], 7 + face_dz[k],
                      16'h8000 | ves_pkg::ID_W'(k));
        end
        send_item(ves_pkg::CMD_READ, 5, 6, 7, '0);
        send_item(ves_pkg::CMD_SCAN, 5, 6, 0, '0);
        // Opening one face uncovers it.
        send_item(ves_pkg::CMD_WRITE, 5, 6, 8, '0);
        send_item(ves_pkg::CMD_READ, 5, 6, 7, '0);
        drain_results();

        random_start = item_count;
        while (item_count - random_start < RANDOM_ITEMS) begin
            // Halfway through, let the block run completely dry once more.
            if (!paused && item_count - random_start >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                build_cluster();
            end else begin
                send_item(ves_pkg::CMD_W'($urandom_range(0, 3)), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          ves_pkg::ID_W'($urandom));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: every accepted result goes to the checker. After each one the
    // receiver may stall for a while, and once it holds off for a long stretch so
    // that the output register and then the input side back up.
    initial begin : result_sink
        int unsigned   hold_left;
        bit            long_hold_done;
        voxel_report_t got;
        hold_left      = 0;
        long_hold_done = 1'b0;
        receiver_calm  = 0;
        m_ready        = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_out_x, m_out_y, m_out_z, m_block_id, m_exposed, m_last};
                board.check_result(got);
                if (!long_hold_done && board.checked >= LONG_HOLD_AFTER) begin
                    long_hold_done = 1'b1;
                    hold_left      = LONG_HOLD_CYCLES;
                end else begin
                    hold_left = pick_gap(receiver_calm);
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any item moving on either side means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
